/* design/lssl_pkg.sv */
package lssl_pkg;

   localparam int SPEED_W     = 16;
   localparam int THRESH_W    = 15;
   localparam int FAULT_CNT_W = 8;
   localparam int STALL_CNT_W = 12;
   localparam int STREAK_W    = 8;
   localparam int CSR_DATA_W  = 15;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 8;

   localparam logic [FAULT_CNT_W-1:0] FAULT_SAT  = 8'hFF;
   localparam logic [STALL_CNT_W-1:0] STALL_SAT  = 12'hFFF;
   localparam logic [STREAK_W-1:0]    STREAK_SAT = 8'd255;

   // unit steps at each counter width
   localparam logic [SPEED_W-1:0]     SPEED_ONE  = 16'd1;
   localparam logic [FAULT_CNT_W-1:0] FAULT_ONE  = 8'd1;
   localparam logic [STALL_CNT_W-1:0] STALL_ONE  = 12'd1;
   localparam logic [STREAK_W-1:0]    STREAK_ONE = 8'd1;

   // previous direction before any item has been seen
   localparam logic [1:0] DIR_NONE = 2'd3;

   typedef enum logic [2:0] {
      REG_RUN_SPEED      = 3'd0,
      REG_STOP_SPEED     = 3'd1,
      REG_ABNORMAL_SPEED = 3'd2,
      REG_FAULT_DEBOUNCE = 3'd3,
      REG_MOVING_STALL   = 3'd4,
      REG_LIMIT_STALL    = 3'd5,
      REG_STREAK_MIN     = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      PRESET_HOLD_LOW   = 3'd0,
      PRESET_HOLD_HIGH  = 3'd1,
      PRESET_LOWER_SLOW = 3'd2,
      PRESET_LOWER_FAST = 3'd3,
      PRESET_RAISE_SLOW = 3'd4,
      PRESET_RAISE_FAST = 3'd5
   } preset_type;

   localparam logic [THRESH_W-1:0]    RST_RUN_SPEED      = 15'd128;
   localparam logic [THRESH_W-1:0]    RST_STOP_SPEED     = 15'd51;
   localparam logic [THRESH_W-1:0]    RST_ABNORMAL_SPEED = 15'd10240;
   localparam logic [FAULT_CNT_W-1:0] RST_FAULT_DEBOUNCE = 8'd5;
   localparam logic [STALL_CNT_W-1:0] RST_MOVING_STALL   = 12'd20;
   localparam logic [STALL_CNT_W-1:0] RST_LIMIT_STALL    = 12'd50;
   localparam logic [STREAK_W-1:0]    RST_STREAK_MIN     = 8'd3;

   typedef struct packed {
      logic [1:0]             prev_dir;
      logic                   stopped;
      logic                   stopped_dir;
      logic                   running;
      logic                   lower_fast;
      logic                   raise_fast;
      logic [FAULT_CNT_W-1:0] fault_ticks;
      logic [STALL_CNT_W-1:0] moving_ticks;
      logic [STALL_CNT_W-1:0] limit_ticks;
      logic [STREAK_W-1:0]    streak;
   } lift_state_type;

   // two's complement magnitude; -32768 gives 32768, which still fits
   function automatic logic [SPEED_W-1:0] speed_mag(input logic [SPEED_W-1:0] v);
      speed_mag = v[SPEED_W-1] ? (~v + SPEED_ONE) : v;
   endfunction

endpackage

/* design/lift_stall_stop_latch.sv */
// Lift stall/stop latch: one transaction on req_ is one control tick of a two-motor lift and
// gives exactly one transaction on rsp_ with the drive preset for that tick and the latch,
// latched direction and running flags after it. The block takes one tick per clock cycle unless
// rsp_tready stalls the result: the tick sits in an input register, then the whole state update
// (direction change, fault and stall debounce counters, stop latch) runs as combinational
// compares and saturating increments into the result register and the state registers.
// Thresholds and debounce counts are written on the csr_ channel by register index (0..6,
// others ignored; upper data bits are dropped) while no tick is in flight, a rule the user
// must keep as the block does not enforce it; csr_ready is always high. Reset is synchronous
// and restores the default register values and clears all tracking state.
module lift_stall_stop_latch (
   input  logic                               clock,
   input  logic                               reset,
   // tick channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [0] direction, [1] fast_request, [17:2] left_speed, [33:18] right_speed,
   // [34] left_fault, [35] right_fault, [39:36] zero
   input  logic [lssl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [2:0] drive_preset, [3] stop_latched, [4] latched_direction, [5] motion_seen,
   // [7:6] zero
   output logic [lssl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [2:0]                         csr_index,
   input  logic [lssl_pkg::CSR_DATA_W-1:0]    csr_data
);

   // configuration registers
   logic [lssl_pkg::THRESH_W-1:0]    run_thresh_ff;
   logic [lssl_pkg::THRESH_W-1:0]    stop_thresh_ff;
   logic [lssl_pkg::THRESH_W-1:0]    abnormal_thresh_ff;
   logic [lssl_pkg::FAULT_CNT_W-1:0] fault_debounce_ff;
   logic [lssl_pkg::STALL_CNT_W-1:0] moving_count_ff;
   logic [lssl_pkg::STALL_CNT_W-1:0] limit_count_ff;
   logic [lssl_pkg::STREAK_W-1:0]    streak_min_ff;

   // input register stage
   logic                             in_valid_ff;
   logic [lssl_pkg::REQ_DATA_W-1:0]  in_data_ff;

   // result register stage
   logic                             out_valid_ff;
   logic [lssl_pkg::RSP_DATA_W-1:0]  out_data_ff;
   logic [lssl_pkg::RSP_DATA_W-1:0]  out_data_in;

   lssl_pkg::lift_state_type         state_ff;
   lssl_pkg::lift_state_type         state_in;

   logic advance;
   logic req_fire;

   // the tick in the input register moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign csr_ready  = 1'b1;

   // configuration writes, truncated to each register's width
   always_ff @(posedge clock) begin
      if (reset) begin
         run_thresh_ff      <= lssl_pkg::RST_RUN_SPEED;
         stop_thresh_ff     <= lssl_pkg::RST_STOP_SPEED;
         abnormal_thresh_ff <= lssl_pkg::RST_ABNORMAL_SPEED;
         fault_debounce_ff  <= lssl_pkg::RST_FAULT_DEBOUNCE;
         moving_count_ff    <= lssl_pkg::RST_MOVING_STALL;
         limit_count_ff     <= lssl_pkg::RST_LIMIT_STALL;
         streak_min_ff      <= lssl_pkg::RST_STREAK_MIN;
      end else if (csr_valid) begin
         case (csr_index)
            lssl_pkg::REG_RUN_SPEED:      run_thresh_ff      <= csr_data;
            lssl_pkg::REG_STOP_SPEED:     stop_thresh_ff     <= csr_data;
            lssl_pkg::REG_ABNORMAL_SPEED: abnormal_thresh_ff <= csr_data;
            lssl_pkg::REG_FAULT_DEBOUNCE:
               fault_debounce_ff <= csr_data[lssl_pkg::FAULT_CNT_W-1:0];
            lssl_pkg::REG_MOVING_STALL:
               moving_count_ff <= csr_data[lssl_pkg::STALL_CNT_W-1:0];
            lssl_pkg::REG_LIMIT_STALL:
               limit_count_ff <= csr_data[lssl_pkg::STALL_CNT_W-1:0];
            lssl_pkg::REG_STREAK_MIN:
               streak_min_ff <= csr_data[lssl_pkg::STREAK_W-1:0];
            default: ; // unused index, write ignored
         endcase
      end
   end

   // unpacked fields of the registered tick
   logic                          dir;
   logic                          fast_req;
   logic [lssl_pkg::SPEED_W-1:0]  left_mag;
   logic [lssl_pkg::SPEED_W-1:0]  right_mag;
   logic                          fault;
   logic [lssl_pkg::SPEED_W-1:0]  run_ext;
   logic [lssl_pkg::SPEED_W-1:0]  stop_ext;
   logic [lssl_pkg::SPEED_W-1:0]  abnormal_ext;
   logic                          stall;
   logic                          debounced;
   lssl_pkg::preset_type          preset;

   assign dir       = in_data_ff[0];
   assign fast_req  = in_data_ff[1];
   assign left_mag  = lssl_pkg::speed_mag(in_data_ff[17:2]);
   assign right_mag = lssl_pkg::speed_mag(in_data_ff[33:18]);
   assign fault     = in_data_ff[34] | in_data_ff[35];

   assign run_ext      = {1'b0, run_thresh_ff};
   assign stop_ext     = {1'b0, stop_thresh_ff};
   assign abnormal_ext = {1'b0, abnormal_thresh_ff};

   // near-zero or implausibly fast on either motor
   assign stall = (left_mag > abnormal_ext) || (left_mag < stop_ext) ||
                  (right_mag > abnormal_ext) || (right_mag < stop_ext);

   // one tick of state update
   always_comb begin
      state_in  = state_ff;
      debounced = 1'b0;

      // sticky fast flag, recorded even while latched
      if (fast_req) begin
         if (dir) state_in.raise_fast = 1'b1;
         else     state_in.lower_fast = 1'b1;
      end

      // direction change releases the latch and restarts stall tracking
      if ({1'b0, dir} != state_ff.prev_dir) begin
         state_in.prev_dir     = {1'b0, dir};
         state_in.stopped      = 1'b0;
         state_in.running      = 1'b0;
         state_in.moving_ticks = '0;
         state_in.limit_ticks  = '0;
         state_in.streak       = '0;
      end

      // preset is picked before this tick's latch check
      if (state_in.stopped) begin
         preset = state_in.stopped_dir ? lssl_pkg::PRESET_HOLD_HIGH
                                       : lssl_pkg::PRESET_HOLD_LOW;
      end else if (dir) begin
         preset = state_in.raise_fast ? lssl_pkg::PRESET_RAISE_FAST
                                      : lssl_pkg::PRESET_RAISE_SLOW;
      end else begin
         preset = state_in.lower_fast ? lssl_pkg::PRESET_LOWER_FAST
                                      : lssl_pkg::PRESET_LOWER_SLOW;
      end

      if (!state_in.stopped) begin
         if (fault) begin
            // fault debounce; stall logic skipped on a fault tick
            if (state_in.fault_ticks < lssl_pkg::FAULT_SAT)
               state_in.fault_ticks = state_in.fault_ticks + lssl_pkg::FAULT_ONE;
            debounced = state_in.fault_ticks >= fault_debounce_ff;
         end else begin
            state_in.fault_ticks = '0;
            if (left_mag > run_ext || right_mag > run_ext)
               state_in.running = 1'b1;
            if (!stall) begin
               state_in.streak = '0;
               if (!state_in.running) begin
                  state_in.moving_ticks = '0;
                  state_in.limit_ticks  = '0;
               end
            end else begin
               if (state_in.running) begin
                  if (state_in.moving_ticks < lssl_pkg::STALL_SAT)
                     state_in.moving_ticks = state_in.moving_ticks + lssl_pkg::STALL_ONE;
                  debounced = state_in.moving_ticks >= moving_count_ff;
               end else begin
                  if (state_in.limit_ticks < lssl_pkg::STALL_SAT)
                     state_in.limit_ticks = state_in.limit_ticks + lssl_pkg::STALL_ONE;
                  debounced = state_in.limit_ticks >= limit_count_ff;
               end
               // debounced stall must also persist for the streak length
               if (debounced) begin
                  if (state_in.streak < lssl_pkg::STREAK_SAT)
                     state_in.streak = state_in.streak + lssl_pkg::STREAK_ONE;
                  debounced = state_in.streak >= streak_min_ff;
               end
            end
         end

         // stop latch: record direction, drop fast flags, clear all counters
         if (debounced) begin
            state_in.stopped      = 1'b1;
            state_in.stopped_dir  = dir;
            state_in.lower_fast   = 1'b0;
            state_in.raise_fast   = 1'b0;
            state_in.running      = 1'b0;
            state_in.fault_ticks  = '0;
            state_in.moving_ticks = '0;
            state_in.limit_ticks  = '0;
            state_in.streak       = '0;
         end
      end

      out_data_in = {2'b00, state_in.running, state_in.stopped_dir,
                     state_in.stopped, preset};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         // previous direction sits in the top bits, everything else clears
         state_ff     <= {lssl_pkg::DIR_NONE,
                          {($bits(lssl_pkg::lift_state_type)-2){1'b0}}};
      end else begin
         if (req_tready)
            in_valid_ff <= req_tvalid;
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire)
         in_data_ff <= req_tdata;
      if (advance)
         out_data_ff <= out_data_in;
   end

`ifndef SYNTHESIS
   // a latched stop never coexists with a running flag
   a_stop_not_running: assert property (@(posedge clock) disable iff (reset)
      state_ff.stopped |-> !state_ff.running)
      else $error("stop latched while running flag set");

   // all debounce counters stay cleared while the latch holds
   a_stop_counters_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff.stopped |-> (state_ff.fault_ticks == '0 && state_ff.moving_ticks == '0 &&
                            state_ff.limit_ticks == '0 && state_ff.streak == '0))
      else $error("counter nonzero while stop latched");

   // a tick waiting behind a stalled result is kept
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |=> in_valid_ff)
      else $error("pending tick dropped under backpressure");

   // once a tick is processed a real direction is recorded
   a_dir_recorded: assert property (@(posedge clock) disable iff (reset)
      advance |=> !state_ff.prev_dir[1])
      else $error("previous direction not recorded");
`endif

endmodule
